// ===== rtl/gffr_pkg.sv =====
`default_nettype none

package gffr_pkg;

    // Grid limits
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;

    // Derived widths
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int WIDTH_W = 7;
    localparam int COL_W   = 64;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Register map, word index taken from paddr[2]
    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(MAX_COLS);

    // Input item
    typedef struct packed {
        logic [COL_W-1:0] wall_mask;
        logic             start_here;
        logic [5:0]       start_col;
        logic             last_row;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [COL_W-1:0] reach_mask;
        logic [5:0]       row_number;
        logic             last_out;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME_A,
        S_PRIME_B,
        S_SWEEP,
        S_PASS_END,
        S_OUT_RD,
        S_OUT_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;
        logic             first_pass;
        logic             clr_changed;
        logic             prime;
        logic             sweep;
        logic             emit;
        logic             finish;
        logic             has_next;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] reach_addr;
        logic [ROW_W-1:0] wall_addr;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [ROW_W-1:0] last_idx;
        logic             changed;
    } t_dp_status;

    // Columns in use; zero acts as one, anything above the limit as the limit
    function automatic logic [COL_W-1:0] col_mask(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] wc;
        wc = w;
        if (wc > WIDTH_W'(MAX_COLS)) wc = WIDTH_W'(MAX_COLS);
        if (wc == '0) wc = WIDTH_W'(1);
        return ~({COL_W{1'b1}} << wc);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gffr_cfg.sv =====
`default_nettype none

module gffr_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gffr_pkg::APB_AW-1:0]    paddr,
    input  wire logic [gffr_pkg::APB_DW-1:0]    pwdata,
    output logic      [gffr_pkg::APB_DW-1:0]    prdata,
    output logic                                pready,
    output logic      [gffr_pkg::COL_W-1:0]     o_cols
);

    logic [gffr_pkg::WIDTH_W-1:0] r_row_width;
    logic                         wr_en;

    // Write on the access phase
    assign wr_en = psel && penable && pwrite && (paddr[2] == gffr_pkg::REG_ROW_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= gffr_pkg::ROW_WIDTH_RESET;
        end else if (wr_en) begin
            r_row_width <= pwdata[gffr_pkg::WIDTH_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == gffr_pkg::REG_ROW_WIDTH) begin
            prdata = gffr_pkg::APB_DW'(r_row_width);
        end
    end

    assign pready = 1'b1;
    assign o_cols = gffr_pkg::col_mask(r_row_width);

endmodule

`default_nettype wire

// ===== rtl/gffr_ctrl.sv =====
`default_nettype none

module gffr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_last_row,
    input  wire gffr_pkg::t_dp_status i_status,
    output gffr_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);

    gffr_pkg::t_state                r_state, n_state;
    logic [gffr_pkg::ROW_W-1:0]      r_row, n_row;
    logic                            r_first, n_first;
    logic                            accept;
    logic                            at_last;

    assign o_busy  = (r_state != gffr_pkg::S_IDLE);
    assign accept  = i_start && !o_busy;
    assign at_last = (r_row == i_status.last_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gffr_pkg::S_IDLE;
            r_row   <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_first <= n_first;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_first = r_first;
        case (r_state)
            gffr_pkg::S_IDLE: begin
                if (accept && i_last_row) begin
                    n_state = gffr_pkg::S_PRIME_A;
                    n_first = 1'b1;
                end
            end
            gffr_pkg::S_PRIME_A: begin
                n_state = gffr_pkg::S_PRIME_B;
            end
            gffr_pkg::S_PRIME_B: begin
                n_state = gffr_pkg::S_SWEEP;
                n_row   = '0;
            end
            gffr_pkg::S_SWEEP: begin
                if (at_last) begin
                    n_state = gffr_pkg::S_PASS_END;
                end else begin
                    n_row = r_row + gffr_pkg::ROW_W'(1);
                end
            end
            gffr_pkg::S_PASS_END: begin
                n_first = 1'b0;
                n_row   = '0;
                if (i_status.changed) begin
                    n_state = gffr_pkg::S_PRIME_A;
                end else begin
                    n_state = gffr_pkg::S_OUT_RD;
                end
            end
            gffr_pkg::S_OUT_RD: begin
                n_state = gffr_pkg::S_OUT_EMIT;
            end
            gffr_pkg::S_OUT_EMIT: begin
                if (at_last) begin
                    n_state = gffr_pkg::S_IDLE;
                end else begin
                    n_state = gffr_pkg::S_OUT_RD;
                    n_row   = r_row + gffr_pkg::ROW_W'(1);
                end
            end
            default: begin
                n_state = gffr_pkg::S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.first_pass = r_first;
        o_cmd.row        = r_row;
        o_cmd.has_next   = !at_last;
        o_cmd.last       = at_last;
        case (r_state)
            gffr_pkg::S_IDLE: begin
                o_cmd.load = accept;
            end
            gffr_pkg::S_PRIME_A: begin
                o_cmd.clr_changed = 1'b1;
                o_cmd.reach_addr  = '0;
            end
            gffr_pkg::S_PRIME_B: begin
                o_cmd.prime      = 1'b1;
                o_cmd.reach_addr = gffr_pkg::ROW_W'(1);
                o_cmd.wall_addr  = '0;
            end
            gffr_pkg::S_SWEEP: begin
                o_cmd.sweep      = 1'b1;
                o_cmd.reach_addr = r_row + gffr_pkg::ROW_W'(2);
                o_cmd.wall_addr  = r_row + gffr_pkg::ROW_W'(1);
            end
            gffr_pkg::S_PASS_END: begin
                o_cmd.reach_addr = '0;
            end
            gffr_pkg::S_OUT_RD: begin
                o_cmd.reach_addr = r_row;
            end
            gffr_pkg::S_OUT_EMIT: begin
                o_cmd.emit   = 1'b1;
                o_cmd.finish = at_last;
            end
            default: begin
                o_cmd.reach_addr = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gffr_dp.sv =====
`default_nettype none

module gffr_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire gffr_pkg::t_dp_cmd        i_cmd,
    input  wire gffr_pkg::t_in_item       i_item,
    input  wire logic [gffr_pkg::COL_W-1:0] i_cols,
    output gffr_pkg::t_dp_status          o_status,
    output logic                          o_strobe,
    output gffr_pkg::t_out_item           o_result
);

    // Row stores
    logic [gffr_pkg::COL_W-1:0] r_wall_mem  [gffr_pkg::MAX_ROWS];
    logic [gffr_pkg::COL_W-1:0] r_reach_mem [gffr_pkg::MAX_ROWS];

    logic [gffr_pkg::CNT_W-1:0] r_rows_loaded;
    logic [gffr_pkg::ROW_W-1:0] r_start_row;
    logic [5:0]                 r_start_col;
    logic                       r_changed;

    // Registered reads and seed substitution for the first pass
    logic [gffr_pkg::COL_W-1:0] r_wall_q;
    logic [gffr_pkg::COL_W-1:0] r_reach_q;
    logic [gffr_pkg::COL_W-1:0] r_init_q;
    logic                       r_use_init;

    // Sweep window
    logic [gffr_pkg::COL_W-1:0] r_prev;
    logic [gffr_pkg::COL_W-1:0] r_cur;

    logic                       r_strobe;
    gffr_pkg::t_out_item        r_out;

    logic                       load_en;
    logic [gffr_pkg::COL_W-1:0] start_bit;
    logic [gffr_pkg::COL_W-1:0] reach_rd;
    logic [gffr_pkg::COL_W-1:0] next_row;
    logic [gffr_pkg::COL_W-1:0] open_cells;
    logic [gffr_pkg::COL_W-1:0] near;
    logic [gffr_pkg::COL_W-1:0] grown;

    assign load_en   = i_cmd.load && (r_rows_loaded < gffr_pkg::CNT_W'(gffr_pkg::MAX_ROWS));
    assign start_bit = (gffr_pkg::COL_W'(1) << r_start_col) & i_cols;
    assign reach_rd  = r_use_init ? r_init_q : r_reach_q;

    // One row of growth
    assign next_row   = i_cmd.has_next ? reach_rd : '0;
    assign open_cells = ~r_wall_q & i_cols;
    assign near       = (r_cur << 1) | (r_cur >> 1) | r_prev | next_row;
    assign grown      = r_cur | (near & open_cells);

    assign o_status.last_idx = r_rows_loaded[gffr_pkg::ROW_W-1:0] - gffr_pkg::ROW_W'(1);
    assign o_status.changed  = r_changed;

    // Wall store
    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_wall_mem[r_rows_loaded[gffr_pkg::ROW_W-1:0]] <= i_item.wall_mask & i_cols;
        end
        r_wall_q <= r_wall_mem[i_cmd.wall_addr];
    end

    // Reach store
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_reach_mem[i_cmd.row] <= grown;
        end
        r_reach_q <= r_reach_mem[i_cmd.reach_addr];
    end

    // Seed value stands in for rows not yet written in this grid
    always_ff @(posedge i_clk) begin
        r_init_q <= (i_cmd.reach_addr == r_start_row) ? start_bit : '0;
    end

    // Load bookkeeping and fill control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_loaded <= '0;
            r_start_row   <= '0;
            r_start_col   <= '0;
            r_changed     <= 1'b0;
            r_use_init    <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_use_init <= i_cmd.first_pass;
            r_strobe   <= i_cmd.emit;
            if (load_en) begin
                r_rows_loaded <= r_rows_loaded + gffr_pkg::CNT_W'(1);
                if (i_item.start_here) begin
                    r_start_row <= r_rows_loaded[gffr_pkg::ROW_W-1:0];
                    r_start_col <= i_item.start_col;
                end
            end
            if (i_cmd.clr_changed) begin
                r_changed <= 1'b0;
            end else if (i_cmd.sweep && (grown != r_cur)) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_rows_loaded <= '0;
                r_start_row   <= '0;
                r_start_col   <= '0;
            end
        end
    end

    // Window shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.prime) begin
            r_prev <= '0;
            r_cur  <= reach_rd;
        end else if (i_cmd.sweep) begin
            r_prev <= grown;
            r_cur  <= reach_rd;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.reach_mask <= reach_rd & i_cols;
            r_out.row_number <= 6'(i_cmd.row);
            r_out.last_out   <= i_cmd.last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== rtl/grid_flood_fill_reachability_top.sv =====
// Rows load at one item per cycle while busy is low; a row without the last flag gives no result.
// After the last row: P passes over the N stored rows, each of PRIME_A, PRIME_B, a SWEEP step
// per row and PASS_END, P being the number of sweeps until one leaves every row unchanged;
// reach climbs at most one row per sweep. Results then follow, each from OUT_RD and OUT_EMIT.
// Synchronous active-low reset clears control state; row stores need no clearing pass.
`default_nettype none

module grid_flood_fill_reachability_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire gffr_pkg::t_in_item             i_item,
    output logic                                o_strobe,
    output gffr_pkg::t_out_item                 o_result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gffr_pkg::APB_AW-1:0]    paddr,
    input  wire logic [gffr_pkg::APB_DW-1:0]    pwdata,
    output logic      [gffr_pkg::APB_DW-1:0]    prdata,
    output logic                                pready
);

    gffr_pkg::t_dp_cmd          cmd;
    gffr_pkg::t_dp_status       status;
    logic [gffr_pkg::COL_W-1:0] cols;

    // Configuration register
    gffr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cols  (cols)
    );

    // Sequencer
    gffr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_last_row (i_item.last_row),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Row stores and growth logic
    gffr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .i_cols   (cols),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // A final row always starts the fill
    a_last_starts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.last_row |=> busy)
        else $error("fill did not start after final row");

    // Results only come out of a running fill
    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result outside a fill");

    // Results of one grid never come back to back; a read state lies between them
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_out |=> !o_strobe)
        else $error("back-to-back results");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gffr_pkg::*;

    localparam int QUIET_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 113;
    localparam int PLAN_ROWS    = 17;
    localparam logic [APB_AW-1:0] ROW_WIDTH_ADDR = {REG_ROW_WIDTH, 2'b00};

    // Directed stimulus: optional width change, one row item, optional typed reach mask
    typedef struct {
        bit                 set_w;
        bit [WIDTH_W-1:0]   width;
        bit [COL_W-1:0]     walls;
        bit                 here;
        bit [5:0]           col;
        bit                 last;
        bit                 has_exp;
        bit [COL_W-1:0]     exp_mask;
    } t_plan_row;

    t_plan_row plan [0:PLAN_ROWS-1] = '{
        // after reset, open row at full width: everything reached
        '{1'b0, 7'd0,   64'h0000_0000_0000_0000, 1'b1, 6'd0,  1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        // start on a wall, boxed in by walls
        '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
        // no start flag: start falls back to the corner
        '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 6'd0,  1'b1, 1'b1, 64'h0000_0000_0000_000F},
        // two start flags, the later row wins
        '{1'b0, 7'd0,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 6'd63, 1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h5555_5555_5555_5554, 1'b1, 6'd0,  1'b1, 1'b0, 64'h0},
        // three rows, no start flag
        '{1'b0, 7'd0,   64'h0000_0000_0000_0002, 1'b0, 6'd9,  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'hFFFF_FFFF_0000_0000, 1'b0, 6'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 6'd0,  1'b1, 1'b0, 64'h0},
        // narrowest width, start column outside it
        '{1'b1, 7'd1,   64'h0000_0000_0000_0000, 1'b1, 6'd5,  1'b1, 1'b1, 64'h0},
        // width zero acts as one, start on a wall
        '{1'b1, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd0,  1'b1, 1'b1, 64'h1},
        // width above the limit acts as the limit
        '{1'b1, 7'd127, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
        // narrow grid, wall bits above the width ignored
        '{1'b1, 7'd5,   64'hFFFF_FFFF_FFFF_FFE4, 1'b0, 6'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h0000_0000_0000_0000, 1'b1, 6'd4,  1'b1, 1'b0, 64'h0},
        // full width, vertical corridor between open rows
        '{1'b1, 7'd64,  64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 6'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h0000_0000_0000_0000, 1'b0, 6'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 6'd0,  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h0000_0000_0000_0000, 1'b0, 6'd0,  1'b1, 1'b0, 64'h0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_in_item            row_in;
    logic                o_strobe;
    t_out_item           result_out;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Predictor state
    logic [COL_W-1:0]    wall_rows [MAX_ROWS];
    logic [WIDTH_W-1:0]  width_reg;
    int                  rows_held;
    int                  seed_row;
    int                  seed_col;
    t_out_item           pending_reach_rows [$];

    // Run bookkeeping
    int                  error_count;
    int                  items_taken;
    int                  grids_done;
    int                  results_seen;
    int                  width_writes;
    int                  quiet_cycles;
    bit                  steady;

    grid_flood_fill_reachability_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (row_in),
        .o_strobe (o_strobe),
        .o_result (result_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Columns in force for a given register value
    function automatic int used_cols(input logic [WIDTH_W-1:0] w);
        int n;
        n = w;
        if (n > MAX_COLS) n = MAX_COLS;
        if (n == 0) n = 1;
        return n;
    endfunction

    function automatic logic [COL_W-1:0] open_cols(input logic [WIDTH_W-1:0] w);
        int n;
        n = used_cols(w);
        return (n >= COL_W) ? '1 : ((COL_W'(1) << n) - COL_W'(1));
    endfunction

    // Spread reach until stable, queue one reach mask per stored row, then clear the grid
    task automatic flood_grid();
        logic [COL_W-1:0] reach [MAX_ROWS];
        logic [COL_W-1:0] cols, cur, free_cells, near, grown;
        t_out_item        res;
        bit               moved;
        int               r;
        cols = open_cols(width_reg);
        for (r = 0; r < MAX_ROWS; r++) reach[r] = '0;
        if (seed_row < rows_held) reach[seed_row] = cols & (COL_W'(1) << seed_col);
        do begin
            moved = 1'b0;
            for (r = 0; r < rows_held; r++) begin
                cur        = reach[r];
                free_cells = ~wall_rows[r] & cols;
                near       = (cur << 1) | (cur >> 1);
                if (r > 0) near |= reach[r-1];
                if (r + 1 < rows_held) near |= reach[r+1];
                grown = cur | (near & free_cells);
                if (grown != cur) begin
                    reach[r] = grown;
                    moved    = 1'b1;
                end
            end
        end while (moved);
        for (r = 0; r < rows_held; r++) begin
            res.reach_mask = reach[r] & cols;
            res.row_number = 6'(r);
            res.last_out   = (r + 1 == rows_held);
            pending_reach_rows.push_back(res);
        end
        rows_held = 0;
        seed_row  = 0;
        seed_col  = 0;
    endtask

    // Predictor update for one accepted row item; rows beyond the store are dropped
    task automatic take_row(input t_in_item it);
        if (rows_held < MAX_ROWS) begin
            wall_rows[rows_held] = it.wall_mask & open_cols(width_reg);
            if (it.start_here) begin
                seed_row = rows_held;
                seed_col = it.start_col;
            end
            rows_held++;
        end
        items_taken++;
        if (it.last_row) begin
            flood_grid();
            grids_done++;
        end
    endtask

    // Present one row item after a random gap and hold it until taken
    task automatic send_row(input t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        row_in <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        take_row(it);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_reach_rows.size() != 0) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready; psel stays high for the next
    task automatic apb_access(input bit wr, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ROW_WIDTH_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    // Width changes only with the block idle and every result in
    task automatic set_width(input logic [WIDTH_W-1:0] w);
        logic [APB_DW-1:0] rd;
        drain_results();
        repeat (8) @(posedge i_clk);
        apb_access(1'b1, APB_DW'(w), rd);
        apb_access(1'b0, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (rd !== APB_DW'(w))
            report_mismatch($sformatf("row_width read back %0h, wrote %0h", rd, w));
        width_reg = w;
        width_writes++;
    endtask

    // Random grid of n rows; tail_start also flags the final row, which may be dropped
    task automatic random_grid(input int n_rows, input bit tail_start);
        t_in_item         it;
        logic [COL_W-1:0] a, b;
        int               seed_at, dens, i;
        seed_at = ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, n_rows - 1);
        dens    = $urandom_range(0, 3);
        steady  = ($urandom_range(0, 3) == 0);
        for (i = 0; i < n_rows; i++) begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
            case (dens)
                0:       it.wall_mask = a & b;
                1:       it.wall_mask = a & b & {$urandom, $urandom};
                2:       it.wall_mask = a;
                default: it.wall_mask = a & b & {$urandom, $urandom} & {$urandom, $urandom};
            endcase
            it.start_here = (i == seed_at) || ($urandom_range(0, 9) == 0)
                            || (tail_start && i == n_rows - 1);
            it.start_col  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                            : 6'($urandom_range(0, used_cols(width_reg) - 1));
            it.last_row   = (i == n_rows - 1);
            send_row(it);
        end
    endtask

    // Result checker: the receiver cannot stall, so every strobe is taken
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            results_seen++;
            if (pending_reach_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected result for row %0d",
                                          result_out.row_number));
            end else begin
                want = pending_reach_rows.pop_front();
                if (result_out.reach_mask !== want.reach_mask)
                    report_mismatch($sformatf("row %0d reach %h, want %h", want.row_number,
                                              result_out.reach_mask, want.reach_mask));
                if (result_out.row_number !== want.row_number)
                    report_mismatch($sformatf("row_number %0d, want %0d",
                                              result_out.row_number, want.row_number));
                if (result_out.last_out !== want.last_out)
                    report_mismatch($sformatf("row %0d last_out %b, want %b", want.row_number,
                                              result_out.last_out, want.last_out));
            end
        end
    end

    // Watchdog on cycles with neither an item taken nor a result given
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no activity for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item   it;
        t_out_item  typed;
        logic [WIDTH_W-1:0] w;
        int i;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        row_in       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        width_reg    = ROW_WIDTH_RESET;
        rows_held    = 0;
        seed_row     = 0;
        seed_col     = 0;
        error_count  = 0;
        items_taken  = 0;
        grids_done   = 0;
        results_seen = 0;
        width_writes = 0;
        quiet_cycles = 0;
        steady       = 1'b0;
        foreach (wall_rows[r]) wall_rows[r] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].set_w) set_width(plan[i].width);
            steady       = ($urandom_range(0, 3) == 0);
            it.wall_mask  = plan[i].walls;
            it.start_here = plan[i].here;
            it.start_col  = plan[i].col;
            it.last_row   = plan[i].last;
            send_row(it);
            // typed masks stand in for the predicted one on single-row grids
            if (plan[i].has_exp) begin
                typed = pending_reach_rows.pop_back();
                typed.reach_mask = plan[i].exp_mask;
                pending_reach_rows.push_back(typed);
            end
        end

        // Overfull grid: rows past the store dropped, flagged start on the final row too
        drain_results();
        random_grid(MAX_ROWS + 2, 1'b1);

        // Mostly small grids, width changed now and then, with occasional full drains
        while (items_taken < PLAN_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0:       w = 7'd0;
                    1:       w = 7'd1;
                    2:       w = 7'd127;
                    3:       w = 7'($urandom_range(65, 126));
                    default: w = 7'($urandom_range(2, 64));
                endcase
                set_width(w);
            end else if ($urandom_range(0, 3) == 0) begin
                drain_results();
            end
            random_grid($urandom_range(1, 6), 1'b0);
        end

        drain_results();
        repeat (16) @(posedge i_clk);

        $display("Run: %0d row items over %0d grids (one overfull), %0d result rows checked,",
                 items_taken, grids_done, results_seen);
        $display("     %0d row_width writes including 0, 1, 64 and above-limit values",
                 width_writes);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
